@@ sv/psg_pkg.sv @@
// Shared types, constants and the mod-251 reduction for the polynomial share generator.
// No dependencies.
package psg_pkg;

  localparam int unsigned FIELD_PRIME = 251;
  localparam int unsigned PIX_W       = 8;
  localparam int unsigned CFG_W       = 5;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned IDX_OUT_W   = 5;
  localparam int unsigned PROD_W      = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_K = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHARE_COUNT = 2'd1;

  // per-cycle command from the control to every cell of the chain
  typedef struct packed {
    logic take;   // pixel transfer: update accumulator and power
    logic load;   // group closes: copy new accumulator into shift stage, restart
    logic shift;  // result transfer: move shift stages one cell toward the output
  } cell_ctl_t;

  // Reduce a 16-bit value mod 251 using 256 == 5 (mod 251).
  function automatic logic [PIX_W-1:0] mod_prime(input logic [PROD_W-1:0] v);
    logic [10:0] v1;
    logic [8:0]  v2;
    v1 = 11'(v[15:8]) * 11'd5 + 11'(v[7:0]);
    v2 = 9'(v1[10:8]) * 9'd5 + 9'(v1[7:0]);
    if (v2 >= 9'(FIELD_PRIME)) begin
      v2 = v2 - 9'(FIELD_PRIME);
    end
    return v2[PIX_W-1:0];
  endfunction

endpackage

@@ sv/polynomial_share_generator.sv @@
// Polynomial share generator: top level, control and the chain of share cells.
// Depends on psg_pkg and psg_cell.
// Output: a group-closing pixel's first share appears the cycle after its transfer;
// the n shares then leave one per cycle from the shift chain while out_stall_i is low.
// Throughput: one pixel per cycle; the output drain of a group runs alongside the next
// group's pixels, and only the pixel that would close a group waits for the drain to end.
// Reset (async, active low): k = n = 2, accumulators 0, powers 1, no result pending.
module polynomial_share_generator #(
  parameter int unsigned MAX_SHARES    = 16,
  parameter int unsigned MAX_THRESHOLD = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [psg_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [psg_pkg::CFG_W-1:0]         cfg_data_i,
  // pixel input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [psg_pkg::PIX_W-1:0]         secret_pixel_i,
  // share output channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [psg_pkg::IDX_OUT_W-1:0]     share_index_o,
  output logic [psg_pkg::PIX_W-1:0]         share_value_o,
  output logic                              last_of_group_o
);

  // pos counts pixels of the open group, always below MAX_THRESHOLD
  localparam int unsigned POS_W  = $clog2(MAX_THRESHOLD + 1);
  localparam int unsigned KW     = (POS_W > psg_pkg::CFG_W) ? POS_W : psg_pkg::CFG_W;
  localparam int unsigned NCNT_W = $clog2(MAX_SHARES + 1);
  localparam int unsigned NW     = (NCNT_W > psg_pkg::CFG_W) ? NCNT_W : psg_pkg::CFG_W;

  logic [psg_pkg::CFG_W-1:0] thr_q, thr_d, cnt_q, cnt_d;
  logic [POS_W-1:0]          pos_q, pos_d;
  logic [NW-1:0]             idx_q, idx_d, n_q, n_d;
  logic                      busy_q, busy_d;

  logic [KW-1:0]             k_eff;
  logic [NW-1:0]             n_eff;
  logic [KW:0]               pos_inc;
  logic                      grp_end, in_xfer, out_xfer, last;
  psg_pkg::cell_ctl_t        ctl;

  // --- configuration: always ready, writes beyond the list are dropped
  assign cfg_ready_o = 1'b1;

  always_comb begin
    thr_d = thr_q;
    cnt_d = cnt_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        psg_pkg::CFG_THRESHOLD_K: thr_d = cfg_data_i;
        psg_pkg::CFG_SHARE_COUNT: cnt_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  // --- saturate register values to the supported range when used
  always_comb begin
    if (KW'(thr_q) < KW'(2)) begin
      k_eff = KW'(2);
    end else if (KW'(thr_q) > KW'(MAX_THRESHOLD)) begin
      k_eff = KW'(MAX_THRESHOLD);
    end else begin
      k_eff = KW'(thr_q);
    end
    if (NW'(cnt_q) < NW'(2)) begin
      n_eff = NW'(2);
    end else if (NW'(cnt_q) > NW'(MAX_SHARES)) begin
      n_eff = NW'(MAX_SHARES);
    end else begin
      n_eff = NW'(cnt_q);
    end
  end

  // group closes once the pixel count reaches k (k may have shrunk mid-group)
  assign pos_inc = (KW + 1)'(pos_q) + (KW + 1)'(1);
  assign grp_end = (pos_inc >= {1'b0, k_eff});

  // a closing pixel waits while the previous group's shares are still draining
  assign in_stall_o = busy_q && grp_end;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_xfer   = busy_q && !out_stall_i;
  assign last       = (idx_q == n_q);

  assign ctl.take  = in_xfer;
  assign ctl.load  = grp_end;
  assign ctl.shift = out_xfer;

  always_comb begin
    pos_d  = pos_q;
    idx_d  = idx_q;
    n_d    = n_q;
    busy_d = busy_q;
    if (out_xfer) begin
      idx_d = idx_q + NW'(1);
      if (last) begin
        busy_d = 1'b0;
      end
    end
    if (in_xfer) begin
      if (grp_end) begin
        pos_d  = '0;
        idx_d  = NW'(1);
        n_d    = n_eff;
        busy_d = 1'b1;
      end else begin
        pos_d = pos_inc[POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= psg_pkg::CFG_W'(2);
      cnt_q  <= psg_pkg::CFG_W'(2);
      pos_q  <= '0;
      idx_q  <= NW'(1);
      n_q    <= NW'(2);
      busy_q <= 1'b0;
    end else begin
      thr_q  <= thr_d;
      cnt_q  <= cnt_d;
      pos_q  <= pos_d;
      idx_q  <= idx_d;
      n_q    <= n_d;
      busy_q <= busy_d;
    end
  end

  // --- chain of share cells; results shift toward cell 0, which drives the output
  logic [psg_pkg::PIX_W-1:0] chain [MAX_SHARES+1];

  assign chain[MAX_SHARES] = '0;

  for (genvar s = 0; s < MAX_SHARES; s++) begin : g_cell
    psg_cell #(
      .X (s + 1)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .pixel_i (secret_pixel_i),
      .shift_i (chain[s+1]),
      .shift_o (chain[s])
    );
  end

  assign out_valid_o     = busy_q;
  assign share_value_o   = chain[0];
  assign share_index_o   = idx_q[psg_pkg::IDX_OUT_W-1:0];
  assign last_of_group_o = last;

endmodule

@@ sv/psg_cell.sv @@
// One share cell: running accumulator and power of x for a fixed evaluation point,
// plus one stage of the result shift chain. Depends on psg_pkg.
module psg_cell #(
  parameter int unsigned X = 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  psg_pkg::cell_ctl_t            ctl_i,
  input  logic [psg_pkg::PIX_W-1:0]     pixel_i,
  input  logic [psg_pkg::PIX_W-1:0]     shift_i,
  output logic [psg_pkg::PIX_W-1:0]     shift_o
);

  logic [psg_pkg::PIX_W-1:0] acc_q, acc_d, pow_q, pow_d, shr_q, shr_d;
  logic [psg_pkg::PIX_W-1:0] acc_new, pow_new;

  always_comb begin
    acc_new = psg_pkg::mod_prime(
        psg_pkg::PROD_W'(pixel_i) * psg_pkg::PROD_W'(pow_q) + psg_pkg::PROD_W'(acc_q));
    pow_new = psg_pkg::mod_prime(psg_pkg::PROD_W'(pow_q) * psg_pkg::PROD_W'(X));
    acc_d = acc_q;
    pow_d = pow_q;
    shr_d = shr_q;
    if (ctl_i.take) begin
      if (ctl_i.load) begin
        acc_d = '0;
        pow_d = psg_pkg::PIX_W'(1);
        shr_d = acc_new;
      end else begin
        acc_d = acc_new;
        pow_d = pow_new;
      end
    end
    if (ctl_i.shift) begin
      shr_d = shift_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      pow_q <= psg_pkg::PIX_W'(1);
    end else begin
      acc_q <= acc_d;
      pow_q <= pow_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shr_q <= shr_d;
  end

  assign shift_o = shr_q;

endmodule

@@ sim/polynomial_share_generator_tb.sv @@
// Self-checking testbench for polynomial_share_generator: pixel driver, share monitor,
// receiver stall pattern and an in-bench mod-251 share predictor.
// Depends on psg_pkg and the polynomial_share_generator RTL.
`timescale 1ns / 100ps

module polynomial_share_generator_tb;

  localparam int unsigned MAX_SHARES    = 16;
  localparam int unsigned MAX_THRESHOLD = 16;
  // after the last expected share, room for a pixel still being absorbed
  localparam int unsigned DRAIN_CYCLES  = 2 * MAX_SHARES + 8;
  localparam int unsigned IDLE_LIMIT    = 4000;
  localparam int unsigned LONG_HOLD     = 250;
  localparam int unsigned RANDOM_ITEMS  = 75;

  // indexes that decode to no register; writes there must be ignored
  localparam logic [psg_pkg::CFG_IDX_W-1:0] CFG_UNUSED_2 = 2'd2;
  localparam logic [psg_pkg::CFG_IDX_W-1:0] CFG_UNUSED_3 = 2'd3;

  typedef struct packed {
    logic [psg_pkg::IDX_OUT_W-1:0] index;
    logic [psg_pkg::PIX_W-1:0]     value;
    logic                          last;
  } share_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_COIN,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  // ---------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic                          clk_i          = 1'b0;
  logic                          rst_ni         = 1'b0;
  logic                          cfg_valid_i    = 1'b0;
  logic                          cfg_ready_o;
  logic [psg_pkg::CFG_IDX_W-1:0] cfg_index_i    = '0;
  logic [psg_pkg::CFG_W-1:0]     cfg_data_i     = '0;
  logic                          in_valid_i     = 1'b0;
  logic                          in_stall_o;
  logic [psg_pkg::PIX_W-1:0]     secret_pixel_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i    = 1'b0;
  logic [psg_pkg::IDX_OUT_W-1:0] share_index_o;
  logic [psg_pkg::PIX_W-1:0]     share_value_o;
  logic                          last_of_group_o;

  always #4 clk_i = ~clk_i;

  polynomial_share_generator #(
    .MAX_SHARES   (MAX_SHARES),
    .MAX_THRESHOLD(MAX_THRESHOLD)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .secret_pixel_i (secret_pixel_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .share_index_o  (share_index_o),
    .share_value_o  (share_value_o),
    .last_of_group_o(last_of_group_o)
  );

  // ---------------------------------------------------------------------------
  // Share predictor state: one accumulator and one running power of x per share,
  // plus the register copies as written (5 bits, saturated only when used).
  // ---------------------------------------------------------------------------
  logic [psg_pkg::CFG_W-1:0] threshold_reg   = 5'd2;
  logic [psg_pkg::CFG_W-1:0] share_count_reg = 5'd2;
  logic [4:0]                coeffs_taken    = '0;
  logic [psg_pkg::PIX_W-1:0] acc_model [MAX_SHARES];
  logic [psg_pkg::PIX_W-1:0] pow_model [MAX_SHARES];

  logic [psg_pkg::PIX_W-1:0] pixel_queue[$];    // pixels waiting for the driver
  share_t                    pending_shares[$]; // predicted shares, oldest first

  int unsigned errors         = 0;
  int unsigned pixels_taken   = 0;
  int unsigned groups_closed  = 0;
  int unsigned shares_checked = 0;
  int unsigned reg_writes     = 0;
  int unsigned random_items   = 0;
  int unsigned idle_cycles    = 0;

  logic hold_armed = 1'b0; // set by the sequence, consumed by the stall process

  function automatic int unsigned clamp_setting(input logic [psg_pkg::CFG_W-1:0] v,
                                                input int unsigned hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  task automatic restart_group();
    coeffs_taken = '0;
    for (int i = 0; i < MAX_SHARES; i++) begin
      acc_model[i] = '0;
      pow_model[i] = 8'd1;
    end
  endtask

  // One pixel is the next coefficient for every share; when the group fills up,
  // the n shares in force now are queued as expected results.
  task automatic absorb_pixel(input logic [psg_pkg::PIX_W-1:0] pix);
    int unsigned k_eff;
    int unsigned n_eff;
    share_t      s;
    k_eff = clamp_setting(threshold_reg, MAX_THRESHOLD);
    n_eff = clamp_setting(share_count_reg, MAX_SHARES);
    for (int i = 0; i < MAX_SHARES; i++) begin
      acc_model[i] = 8'((32'(acc_model[i]) + 32'(pix) * 32'(pow_model[i]))
                        % psg_pkg::FIELD_PRIME);
      pow_model[i] = 8'((32'(pow_model[i]) * 32'(i + 1)) % psg_pkg::FIELD_PRIME);
    end
    coeffs_taken = coeffs_taken + 5'd1;
    pixels_taken++;
    // a threshold lowered mid-group closes at the first pixel at or past it
    if (coeffs_taken >= k_eff) begin
      for (int i = 0; i < n_eff; i++) begin
        s.index = 5'(i + 1);
        s.value = acc_model[i];
        s.last  = (i + 1 == n_eff);
        pending_shares.push_back(s);
      end
      groups_closed++;
      restart_group();
    end
  endtask

  initial restart_group();

  // ---------------------------------------------------------------------------
  // Pixel driver: bursts of random length separated by random gaps. A new pixel
  // is presented only when the slot is free, so a stalled pixel holds still.
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pixel_queue.size() != 0) begin
          in_valid_i     <= 1'b1;
          secret_pixel_i <= pixel_queue.pop_front();
          if (burst_left != 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            // a quarter of bursts run straight into the next one
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver stall: stretches of a randomly chosen pattern, plus one long hold
  // once armed, so the block backs up and has to stall its pixel input.
  // ---------------------------------------------------------------------------
  stall_mode_e stall_mode   = STALL_NONE;
  int unsigned mode_left    = 0;
  int unsigned hold_left    = 0;
  bit          hold_done    = 1'b0;
  logic [2:0]  stall_phase  = '0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      stall_phase <= stall_phase + 3'd1;
      if (hold_armed && !hold_done) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = stall_mode_e'($urandom_range(0, 3));
          mode_left  = $urandom_range(5, 40);
        end
        mode_left--;
        case (stall_mode)
          STALL_NONE:     out_stall_i <= 1'b0;
          STALL_COIN:     out_stall_i <= 1'($urandom_range(0, 1));
          STALL_HEAVY:    out_stall_i <= ($urandom_range(0, 3) != 0);
          STALL_PERIODIC: out_stall_i <= stall_phase[2];
          default:        out_stall_i <= 1'b0;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each share transfer against the oldest prediction, then
  // predicts from the pixel transfer of the same edge. Also the idle watchdog.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    bit     moved;
    share_t want;
    if (rst_ni) begin
      moved = cfg_valid_i && cfg_ready_o;
      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        if (pending_shares.size() == 0) begin
          errors++;
          $display("%0t: unexpected share x=%0d value=%0d last=%0b", $time,
                   share_index_o, share_value_o, last_of_group_o);
        end else begin
          want = pending_shares.pop_front();
          shares_checked++;
          if (share_index_o !== want.index) begin
            errors++;
            $display("%0t: share_index expected %0d, got %0d", $time,
                     want.index, share_index_o);
          end
          if (share_value_o !== want.value) begin
            errors++;
            $display("%0t: share_value (x=%0d) expected %0d, got %0d", $time,
                     want.index, want.value, share_value_o);
          end
          if (last_of_group_o !== want.last) begin
            errors++;
            $display("%0t: last_of_group (x=%0d) expected %0b, got %0b", $time,
                     want.index, want.last, last_of_group_o);
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        moved = 1'b1;
        absorb_pixel(secret_pixel_i);
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d shares still expected",
                 $time, idle_cycles, pending_shares.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence helpers
  // ---------------------------------------------------------------------------
  // Register write; only called while the block is idle, so the copy can be
  // updated right at the transfer.
  task automatic write_reg(input logic [psg_pkg::CFG_IDX_W-1:0] idx,
                           input logic [psg_pkg::CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    reg_writes++;
    case (idx)
      psg_pkg::CFG_THRESHOLD_K: threshold_reg = data;
      psg_pkg::CFG_SHARE_COUNT: share_count_reg = data;
      default: ;
    endcase
  endtask

  // Wait until every pixel is taken and every predicted share has left, then
  // give a pixel inside a group time to finish.
  task automatic settle();
    while (pixel_queue.size() != 0 || in_valid_i || pending_shares.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Mostly in range, with the bounds and out-of-range values now and then.
  function automatic logic [psg_pkg::CFG_W-1:0] pick_setting();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 5'($urandom_range(0, 1));
    if (r == 1) return 5'($urandom_range(17, 31));
    if (r == 2) return $urandom_range(0, 1) ? 5'd2 : 5'd16;
    return 5'($urandom_range(2, 16));
  endfunction

  task automatic feed_random(input int unsigned count);
    int r;
    @(negedge clk_i);
    repeat (count) begin
      r = $urandom_range(0, 7);
      if (r == 0) pixel_queue.push_back(8'($urandom_range(251, 255)));
      else if (r == 1) pixel_queue.push_back($urandom_range(0, 1) ? 8'd255 : 8'd0);
      else pixel_queue.push_back(8'($urandom_range(0, 255)));
    end
    random_items += count;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [psg_pkg::PIX_W-1:0] corners[4];
    int r;
    corners = '{8'd255, 8'd0, 8'd251, 8'd250};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings (k = n = 2) with byte extremes; 251 acts as zero
    @(negedge clk_i);
    foreach (corners[i]) pixel_queue.push_back(corners[i]);
    settle();

    // largest group and most shares
    write_reg(psg_pkg::CFG_THRESHOLD_K, 5'd16);
    write_reg(psg_pkg::CFG_SHARE_COUNT, 5'd16);
    @(negedge clk_i);
    for (int i = 0; i < 16; i++) pixel_queue.push_back(i[0] ? 8'd255 : 8'(i * 17));
    settle();

    // out-of-range settings saturate; unused indexes leave both registers alone
    write_reg(psg_pkg::CFG_THRESHOLD_K, 5'd0);
    write_reg(psg_pkg::CFG_SHARE_COUNT, 5'd31);
    write_reg(CFG_UNUSED_2, 5'd7);
    write_reg(CFG_UNUSED_3, 5'd31);
    @(negedge clk_i);
    pixel_queue.push_back(8'd1);
    pixel_queue.push_back(8'd128);
    settle();

    // partial group, then the threshold drops to the number of pixels already taken
    write_reg(psg_pkg::CFG_THRESHOLD_K, 5'd16);
    write_reg(psg_pkg::CFG_SHARE_COUNT, 5'd5);
    @(negedge clk_i);
    pixel_queue.push_back(8'd252);
    pixel_queue.push_back(8'd253);
    pixel_queue.push_back(8'd254);
    settle();
    write_reg(psg_pkg::CFG_THRESHOLD_K, 5'd3);
    write_reg(psg_pkg::CFG_SHARE_COUNT, 5'd3);
    @(negedge clk_i);
    pixel_queue.push_back(8'd7);
    settle();

    // back-pressure: short groups, many shares, and a long receiver hold
    write_reg(psg_pkg::CFG_THRESHOLD_K, 5'd2);
    write_reg(psg_pkg::CFG_SHARE_COUNT, 5'd16);
    hold_armed <= 1'b1;
    feed_random(30);
    settle();

    // random settings per phase; groups often straddle a settings change
    while (random_items < RANDOM_ITEMS) begin
      r = $urandom_range(0, 5);
      if (r != 0) write_reg(psg_pkg::CFG_THRESHOLD_K, pick_setting());
      if (r != 1) write_reg(psg_pkg::CFG_SHARE_COUNT, pick_setting());
      if (r == 2) write_reg($urandom_range(0, 1) ? CFG_UNUSED_2 : CFG_UNUSED_3, 5'($urandom));
      feed_random($urandom_range(6, 20));
      settle();
    end

    $display("Run covered %0d pixels in %0d groups, %0d shares checked, %0d register writes.",
             pixels_taken, groups_closed, shares_checked, reg_writes);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", errors);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
